@@ hw/rtl/gpr_pkg.sv @@
// ----------------------------------------------------------------------------
// gpr_pkg
// Shared types, key codes and helper functions for the gamepad report builder.
// ----------------------------------------------------------------------------
package gpr_pkg;

   // event kinds carried on req_tuser
   typedef enum logic [1:0] {
      OP_KEY      = 2'd0,
      OP_ANALOG   = 2'd1,
      OP_ENABLE   = 2'd2,
      OP_RESERVED = 2'd3
   } op_type;

   // key ids, taken modulo 128
   localparam logic [6:0] KEY_UP     = 7'd1;
   localparam logic [6:0] KEY_DOWN   = 7'd2;
   localparam logic [6:0] KEY_LEFT   = 7'd3;
   localparam logic [6:0] KEY_RIGHT  = 7'd4;
   localparam logic [6:0] KEY_X      = 7'd20;
   localparam logic [6:0] KEY_LB     = 7'd21;
   localparam logic [6:0] KEY_A      = 7'd22;
   localparam logic [6:0] KEY_RB     = 7'd23;
   localparam logic [6:0] KEY_BACK   = 7'd52;
   localparam logic [6:0] KEY_A_ALT  = 7'd54;
   localparam logic [6:0] KEY_L3     = 7'd55;
   localparam logic [6:0] KEY_R3     = 7'd56;

   // d-pad flag positions
   localparam int DPAD_UP    = 0;
   localparam int DPAD_DOWN  = 1;
   localparam int DPAD_LEFT  = 2;
   localparam int DPAD_RIGHT = 3;

   // button bit positions
   localparam int BTN_A    = 0;
   localparam int BTN_X    = 2;
   localparam int BTN_LB   = 4;
   localparam int BTN_RB   = 5;
   localparam int BTN_BACK = 6;
   localparam int BTN_L3   = 8;
   localparam int BTN_R3   = 9;

   // hat codes
   localparam logic [3:0] HAT_UP         = 4'd0;
   localparam logic [3:0] HAT_UP_RIGHT   = 4'd1;
   localparam logic [3:0] HAT_RIGHT      = 4'd2;
   localparam logic [3:0] HAT_DOWN_RIGHT = 4'd3;
   localparam logic [3:0] HAT_DOWN       = 4'd4;
   localparam logic [3:0] HAT_DOWN_LEFT  = 4'd5;
   localparam logic [3:0] HAT_LEFT       = 4'd6;
   localparam logic [3:0] HAT_UP_LEFT    = 4'd7;
   localparam logic [3:0] HAT_NEUTRAL    = 4'd8;

   localparam logic signed [18:0] AXIS_MAX = 19'sd32767;
   localparam logic signed [18:0] AXIS_MIN = -19'sd32767;

   typedef struct packed {
      logic               host_ready;
      logic               enable_value;
      logic signed [15:0] raw_y;
      logic signed [15:0] raw_x;
      logic [7:0]         device_code;
      logic [15:0]        key_code;
      logic               pressed;
      op_type             opcode;
   } event_type;

   typedef struct packed {
      logic               enabled;
      logic [3:0]         dpad;
      logic [9:0]         buttons;
      logic signed [15:0] left_x;
      logic signed [15:0] left_y;
      logic signed [15:0] right0_x;
      logic signed [15:0] right0_y;
      logic signed [15:0] right1_x;
      logic signed [15:0] right1_y;
   } pad_state_type;

   localparam pad_state_type PAD_RESET = '{
      enabled: 1'b1, dpad: '0, buttons: '0,
      left_x: '0, left_y: '0, right0_x: '0, right0_y: '0,
      right1_x: '0, right1_y: '0
   };

   // outcome of one event, handed from the state keeper to the report former
   typedef struct packed {
      logic          emit;
      logic          neutral;
      pad_state_type pad;
   } step_type;

   typedef struct packed {
      logic signed [15:0] report_right_y;
      logic signed [15:0] report_right_x;
      logic signed [15:0] report_left_y;
      logic signed [15:0] report_left_x;
      logic [3:0]         hat_code;
      logic [9:0]         button_bits;
   } report_type;

   // scale by 8 and clamp to +-32767
   function automatic logic signed [15:0] scale_sat(input logic signed [15:0] raw);
      logic signed [18:0] s;
      s = {raw, 3'b000};
      if (s > AXIS_MAX) begin
         s = AXIS_MAX;
      end else if (s < AXIS_MIN) begin
         s = AXIS_MIN;
      end
      return s[15:0];
   endfunction

   // diagonals first, then single directions
   function automatic logic [3:0] hat_of(input logic [3:0] d);
      logic up, down, left, right;
      logic [3:0] h;
      up    = d[DPAD_UP];
      down  = d[DPAD_DOWN];
      left  = d[DPAD_LEFT];
      right = d[DPAD_RIGHT];
      if (up && right)        h = HAT_UP_RIGHT;
      else if (right && down) h = HAT_DOWN_RIGHT;
      else if (down && left)  h = HAT_DOWN_LEFT;
      else if (left && up)    h = HAT_UP_LEFT;
      else if (up)            h = HAT_UP;
      else if (right)         h = HAT_RIGHT;
      else if (down)          h = HAT_DOWN;
      else if (left)          h = HAT_LEFT;
      else                    h = HAT_NEUTRAL;
      return h;
   endfunction

endpackage

@@ hw/rtl/gpr_state_keeper.sv @@
// ----------------------------------------------------------------------------
// gpr_state_keeper
// Holds the gamepad state and applies one event per cycle to it while apply is high.
// ----------------------------------------------------------------------------
module gpr_state_keeper #(
   parameter int SLOT_COUNT = 5
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               apply,
   input  gpr_pkg::event_type ev,
   output gpr_pkg::step_type  step
);
   import gpr_pkg::*;

   localparam logic [6:0] SLOT_LIMIT = 7'(SLOT_COUNT);

   pad_state_type pad_ff;
   pad_state_type pad_in;

   logic [6:0] key;
   logic [6:0] slot;
   logic       right_stick;
   logic       kept;
   logic signed [15:0] sx;
   logic signed [15:0] sy;

   assign key         = ev.key_code[6:0];
   assign slot        = ev.device_code[6:0];
   assign right_stick = ev.device_code[7];
   assign kept        = slot < SLOT_LIMIT;
   assign sx          = scale_sat(ev.raw_x);
   assign sy          = scale_sat(ev.raw_y);

   always_comb begin
      pad_in       = pad_ff;
      step.emit    = 1'b0;
      step.neutral = 1'b0;
      unique case (ev.opcode)
         OP_KEY: begin
            unique case (key) inside
               KEY_UP:            pad_in.dpad[DPAD_UP]     = ev.pressed;
               KEY_DOWN:          pad_in.dpad[DPAD_DOWN]   = ev.pressed;
               KEY_LEFT:          pad_in.dpad[DPAD_LEFT]   = ev.pressed;
               KEY_RIGHT:         pad_in.dpad[DPAD_RIGHT]  = ev.pressed;
               KEY_A, KEY_A_ALT:  pad_in.buttons[BTN_A]    = ev.pressed;
               KEY_X:             pad_in.buttons[BTN_X]    = ev.pressed;
               KEY_LB:            pad_in.buttons[BTN_LB]   = ev.pressed;
               KEY_RB:            pad_in.buttons[BTN_RB]   = ev.pressed;
               KEY_BACK:          pad_in.buttons[BTN_BACK] = ev.pressed;
               KEY_L3:            pad_in.buttons[BTN_L3]   = ev.pressed;
               KEY_R3:            pad_in.buttons[BTN_R3]   = ev.pressed;
               default: ;
            endcase
            step.emit = pad_ff.enabled && ev.host_ready;
         end
         OP_ANALOG: begin
            if (kept) begin
               if (!right_stick && slot == 7'd0) begin
                  pad_in.left_x = sx;
                  pad_in.left_y = sy;
               end else if (right_stick && slot == 7'd0) begin
                  pad_in.right0_x = sx;
                  pad_in.right0_y = sy;
               end else if (right_stick && slot == 7'd1) begin
                  pad_in.right1_x = sx;
                  pad_in.right1_y = sy;
               end
               step.emit = pad_ff.enabled && ev.host_ready;
            end
         end
         OP_ENABLE: begin
            pad_in.enabled = ev.enable_value;
            step.emit      = !ev.enable_value && ev.host_ready;
            step.neutral   = 1'b1;
         end
         default: ;
      endcase
      step.pad = pad_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pad_ff <= PAD_RESET;
      end else if (apply) begin
         pad_ff <= pad_in;
      end
   end

endmodule

@@ hw/rtl/gpr_report_former.sv @@
// ----------------------------------------------------------------------------
// gpr_report_former
// Forms the report fields from the updated state: hat, stick choice, neutral.
// ----------------------------------------------------------------------------
module gpr_report_former (
   input  gpr_pkg::step_type   step,
   output gpr_pkg::report_type report
);
   import gpr_pkg::*;

   logic use_slot1;

   // fall back to slot 1 only when slot 0 is centred and slot 1 is not
   assign use_slot1 = (step.pad.right0_x == '0) && (step.pad.right0_y == '0) &&
                      ((step.pad.right1_x != '0) || (step.pad.right1_y != '0));

   always_comb begin
      if (step.neutral) begin
         report          = '0;
         report.hat_code = HAT_NEUTRAL;
      end else begin
         report.button_bits    = step.pad.buttons;
         report.hat_code       = hat_of(step.pad.dpad);
         report.report_left_x  = step.pad.left_x;
         report.report_left_y  = step.pad.left_y;
         report.report_right_x = use_slot1 ? step.pad.right1_x : step.pad.right0_x;
         report.report_right_y = use_slot1 ? step.pad.right1_y : step.pad.right0_y;
      end
   end

endmodule

@@ hw/rtl/gamepad_report_builder.sv @@
// ----------------------------------------------------------------------------
// gamepad_report_builder
// Turns key, analog-stick and enable events into gamepad reports.
// ----------------------------------------------------------------------------
//  channel | direction | tdata (low bit up)                          | tuser
//  req_    | in        | pressed, key_code, device_code, raw_x,      | opcode
//          |           | raw_y, enable_value, host_ready (64 bits)   |
//  rsp_    | out       | button_bits, hat_code, report_left_x/y,     | -
//          |           | report_right_x/y (80 bits)                  |
//
//  One event is taken per cycle unless a held report stalls it; a report
//  is offered on rsp_ after the input register, then the result register.
//  State update and report forming sit in one combinational step between
//  the two registers, so consecutive events see each other's effects.
//  Reset is synchronous: state returns to enabled, all flags and axes zero.
//  A report held on rsp_ stalls only an event that would give a report;
//  events that give none still drain.
// ----------------------------------------------------------------------------
module gamepad_report_builder #(
   parameter int SLOT_COUNT = 5
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   // [0] pressed, [16:1] key_code, [24:17] device_code, [40:25] raw_x,
   // [56:41] raw_y, [57] enable_value, [58] host_ready, [63:59] zero
   input  logic [63:0] req_tdata,
   // [1:0] opcode
   input  logic [1:0]  req_tuser,
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   // [9:0] button_bits, [13:10] hat_code, [29:14] report_left_x,
   // [45:30] report_left_y, [61:46] report_right_x, [77:62] report_right_y,
   // [79:78] zero
   output logic [79:0] rsp_tdata
);
   import gpr_pkg::*;

   // input register
   logic       in_valid_ff;
   logic       in_valid_in;
   event_type  in_event_ff;
   event_type  req_event;

   // result register
   logic       rsp_valid_ff;
   logic       rsp_valid_in;
   report_type rsp_data_ff;

   step_type   step;
   report_type report;
   logic       req_fire;
   logic       out_free;
   logic       advance;

   // unpack the incoming transfer
   assign req_event.opcode       = op_type'(req_tuser);
   assign req_event.pressed      = req_tdata[0];
   assign req_event.key_code     = req_tdata[16:1];
   assign req_event.device_code  = req_tdata[24:17];
   assign req_event.raw_x        = req_tdata[40:25];
   assign req_event.raw_y        = req_tdata[56:41];
   assign req_event.enable_value = req_tdata[57];
   assign req_event.host_ready   = req_tdata[58];

   gpr_state_keeper #(
      .SLOT_COUNT(SLOT_COUNT)
   ) u_state (
      .clock (clock),
      .reset (reset),
      .apply (advance),
      .ev    (in_event_ff),
      .step  (step)
   );

   gpr_report_former u_former (
      .step   (step),
      .report (report)
   );

   // hold the event only if it needs the result register and that is full and not being taken
   assign out_free   = !rsp_valid_ff || rsp_tready;
   assign advance    = in_valid_ff && (!step.emit || out_free);
   assign req_tready = !in_valid_ff || advance;
   assign req_fire   = req_tvalid && req_tready;

   always_comb begin
      in_valid_in = in_valid_ff;
      if (req_fire) begin
         in_valid_in = 1'b1;
      end else if (advance) begin
         in_valid_in = 1'b0;
      end
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (advance && step.emit) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_fire) begin
         in_event_ff <= req_event;
      end
      if (advance && step.emit) begin
         rsp_data_ff <= report;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {2'b00, rsp_data_ff};

`ifndef SYNTHESIS
   // a disable with the host ready must give a neutral report next cycle
   a_disable_neutral: assert property (@(posedge clock) disable iff (reset)
      (advance && in_event_ff.opcode == OP_ENABLE && !in_event_ff.enable_value &&
       in_event_ff.host_ready)
      |=> (rsp_valid_ff && rsp_data_ff.hat_code == HAT_NEUTRAL &&
           rsp_data_ff.button_bits == '0))
      else $error("disable event did not give a neutral report");

   // an event without a report must not raise an empty result register
   a_no_phantom: assert property (@(posedge clock) disable iff (reset)
      (advance && !step.emit && !rsp_valid_ff) |=> !rsp_valid_ff)
      else $error("report raised by an event that gives none");

   // a report is never overwritten before it is taken
   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && !rsp_tready) |-> !(advance && step.emit))
      else $error("pending report overwritten");

   // hat codes stay in range and saturation keeps every axis off the most negative code
   a_axis_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> (rsp_data_ff.hat_code <= HAT_NEUTRAL &&
                        rsp_data_ff.report_left_x  != -16'sd32768 &&
                        rsp_data_ff.report_left_y  != -16'sd32768 &&
                        rsp_data_ff.report_right_x != -16'sd32768 &&
                        rsp_data_ff.report_right_y != -16'sd32768))
      else $error("report field out of range");
`endif

endmodule

@@ sim/testbench.sv @@
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for gamepad_report_builder. It runs directed events
// first, then streams of random events under changing back-pressure. An
// in-bench copy of the pad state predicts every report, and a scoreboard
// checks each report transfer field by field.
// ----------------------------------------------------------------------------
module testbench;
   import gpr_pkg::*;

   localparam int SLOTS            = 5;
   localparam int CYCLE_LIMIT      = 200000;
   localparam int RANDOM_PER_PHASE = 245;
   localparam int SETTLE_CYCLES    = 8;
   localparam int SINK_HOLD_CYCLES = 60;

   // -------------------------------------------------------------------------
   // Pad state predictor and queue of expected reports
   // -------------------------------------------------------------------------
   class report_scoreboard;
      logic               enabled;
      logic [3:0]         dpad;
      logic [9:0]         buttons;
      logic signed [15:0] left_x;
      logic signed [15:0] left_y;
      logic signed [15:0] right_x [2];
      logic signed [15:0] right_y [2];
      report_type         pending_reports [$];
      int unsigned        mismatches;

      function new();
         enabled    = 1'b1;
         dpad       = '0;
         buttons    = '0;
         left_x     = '0;
         left_y     = '0;
         right_x    = '{16'sd0, 16'sd0};
         right_y    = '{16'sd0, 16'sd0};
         mismatches = 0;
      endfunction

      // scale by eight, clamp symmetrically
      function logic signed [15:0] axis_scaled(input logic signed [15:0] raw);
         int v;
         v = 8 * int'(raw);
         if (v > 32767) begin
            v = 32767;
         end else if (v < -32767) begin
            v = -32767;
         end
         return v[15:0];
      endfunction

      // d-pad bits are {right, left, down, up}; first match wins
      function logic [3:0] hat_for_dpad(input logic [3:0] d);
         casez (d)
            4'b1??1: return HAT_UP_RIGHT;
            4'b1?1?: return HAT_DOWN_RIGHT;
            4'b?11?: return HAT_DOWN_LEFT;
            4'b?1?1: return HAT_UP_LEFT;
            4'b???1: return HAT_UP;
            4'b1???: return HAT_RIGHT;
            4'b??1?: return HAT_DOWN;
            4'b?1??: return HAT_LEFT;
            default: return HAT_NEUTRAL;
         endcase
      endfunction

      // update the pad state for one accepted event, queue its report if any
      function void note_event(input event_type ev);
         logic [6:0] slot;
         logic       gives_report;
         report_type r;
         slot         = ev.device_code[6:0];
         gives_report = 1'b0;
         r            = '0;
         case (ev.opcode)
            OP_KEY: begin
               case (ev.key_code[6:0])
                  KEY_UP:           dpad[DPAD_UP]     = ev.pressed;
                  KEY_DOWN:         dpad[DPAD_DOWN]   = ev.pressed;
                  KEY_LEFT:         dpad[DPAD_LEFT]   = ev.pressed;
                  KEY_RIGHT:        dpad[DPAD_RIGHT]  = ev.pressed;
                  KEY_A, KEY_A_ALT: buttons[BTN_A]    = ev.pressed;
                  KEY_X:            buttons[BTN_X]    = ev.pressed;
                  KEY_LB:           buttons[BTN_LB]   = ev.pressed;
                  KEY_RB:           buttons[BTN_RB]   = ev.pressed;
                  KEY_BACK:         buttons[BTN_BACK] = ev.pressed;
                  KEY_L3:           buttons[BTN_L3]   = ev.pressed;
                  KEY_R3:           buttons[BTN_R3]   = ev.pressed;
                  default: ;
               endcase
               gives_report = 1'b1;
            end
            OP_ANALOG: begin
               // out-of-range slots vanish; unread slots still report
               if (slot < SLOTS) begin
                  if (!ev.device_code[7] && slot == 0) begin
                     left_x = axis_scaled(ev.raw_x);
                     left_y = axis_scaled(ev.raw_y);
                  end else if (ev.device_code[7] && slot < 2) begin
                     right_x[slot[0]] = axis_scaled(ev.raw_x);
                     right_y[slot[0]] = axis_scaled(ev.raw_y);
                  end
                  gives_report = 1'b1;
               end
            end
            OP_ENABLE: begin
               enabled = ev.enable_value;
               if (!ev.enable_value && ev.host_ready) begin
                  r.hat_code = HAT_NEUTRAL;
                  pending_reports.push_back(r);
               end
            end
            default: ;
         endcase
         if (gives_report && enabled && ev.host_ready) begin
            r.button_bits    = buttons;
            r.hat_code       = hat_for_dpad(dpad);
            r.report_left_x  = left_x;
            r.report_left_y  = left_y;
            r.report_right_x = right_x[0];
            r.report_right_y = right_y[0];
            // fall back to slot 1 only when slot 0 rests and slot 1 does not
            if (right_x[0] == 0 && right_y[0] == 0 && (right_x[1] != 0 || right_y[1] != 0))
            begin
               r.report_right_x = right_x[1];
               r.report_right_y = right_y[1];
            end
            pending_reports.push_back(r);
         end
      endfunction

      function void compare_field(input string name, input logic signed [31:0] expected,
                                  input logic signed [31:0] actual);
         if (actual !== expected) begin
            $display("%0t: %s expected %0d got %0d", $time, name, expected, actual);
            mismatches++;
         end
      endfunction

      // compare one report transfer with the oldest expectation
      function void check_report(input logic [79:0] data);
         report_type got;
         report_type want;
         got = data[77:0];
         if (pending_reports.size() == 0) begin
            $display("%0t: report with none expected, expected nothing got %h", $time, data);
            mismatches++;
            return;
         end
         want = pending_reports.pop_front();
         compare_field("button_bits", want.button_bits, got.button_bits);
         compare_field("hat_code", want.hat_code, got.hat_code);
         compare_field("report_left_x", want.report_left_x, got.report_left_x);
         compare_field("report_left_y", want.report_left_y, got.report_left_y);
         compare_field("report_right_x", want.report_right_x, got.report_right_x);
         compare_field("report_right_y", want.report_right_y, got.report_right_y);
      endfunction
   endclass

   // -------------------------------------------------------------------------
   // Signals and block under test
   // -------------------------------------------------------------------------
   logic        clock;
   logic        reset;
   logic        req_tvalid;
   logic        req_tready;
   logic [63:0] req_tdata;
   logic [1:0]  req_tuser;
   logic        rsp_tvalid;
   logic        rsp_tready;
   logic [79:0] rsp_tdata;

   int unsigned src_idle_pct;
   int unsigned sink_idle_pct;
   int unsigned sink_hold_request;
   int unsigned cycle_count;

   report_scoreboard reports = new();

   gamepad_report_builder #(
      .SLOT_COUNT (SLOTS)
   ) uut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   // -------------------------------------------------------------------------
   // Event builders
   // -------------------------------------------------------------------------
   function automatic logic [6:0] mapped_key(input int unsigned index);
      case (index)
         0:       return KEY_UP;
         1:       return KEY_DOWN;
         2:       return KEY_LEFT;
         3:       return KEY_RIGHT;
         4:       return KEY_X;
         5:       return KEY_LB;
         6:       return KEY_A;
         7:       return KEY_RB;
         8:       return KEY_BACK;
         9:       return KEY_A_ALT;
         10:      return KEY_L3;
         default: return KEY_R3;
      endcase
   endfunction

   function automatic event_type key_event(input logic [15:0] code, input logic pressed,
                                           input logic host_ready);
      event_type ev;
      ev            = '0;
      ev.opcode     = OP_KEY;
      ev.key_code   = code;
      ev.pressed    = pressed;
      ev.host_ready = host_ready;
      return ev;
   endfunction

   function automatic event_type analog_event(input logic [7:0] device, input logic [15:0] x,
                                              input logic [15:0] y, input logic host_ready);
      event_type ev;
      ev             = '0;
      ev.opcode      = OP_ANALOG;
      ev.device_code = device;
      ev.raw_x       = x;
      ev.raw_y       = y;
      ev.host_ready  = host_ready;
      return ev;
   endfunction

   function automatic event_type enable_event(input logic value, input logic host_ready);
      event_type ev;
      ev              = '0;
      ev.opcode       = OP_ENABLE;
      ev.enable_value = value;
      ev.host_ready   = host_ready;
      return ev;
   endfunction

   // mostly well-formed events on mapped keys and read slots, with random noise
   function automatic event_type random_event();
      event_type   ev;
      int unsigned pick;
      ev.pressed      = 1'($urandom_range(1));
      ev.key_code     = 16'($urandom);
      ev.device_code  = 8'($urandom);
      ev.raw_x        = 16'($urandom);
      ev.raw_y        = 16'($urandom);
      ev.enable_value = ($urandom_range(99) < 70);
      ev.host_ready   = ($urandom_range(99) < 85);
      pick = $urandom_range(99);
      if (pick < 45) begin
         ev.opcode = OP_KEY;
      end else if (pick < 85) begin
         ev.opcode = OP_ANALOG;
      end else if (pick < 96) begin
         ev.opcode = OP_ENABLE;
      end else begin
         ev.opcode = OP_RESERVED;
      end
      // keep random upper key bits, steer the low seven onto mapped ids
      if ($urandom_range(99) < 75) begin
         ev.key_code[6:0] = mapped_key($urandom_range(11));
      end
      pick = $urandom_range(99);
      if (pick < 75) begin
         ev.device_code[6:0] = 7'($urandom_range(1));
      end else if (pick < 90) begin
         ev.device_code[6:0] = 7'($urandom_range(SLOTS - 1, 2));
      end
      // zero sticks often enough to exercise the right-slot fallback
      pick = $urandom_range(99);
      if (pick < 20) begin
         ev.raw_x = '0;
         ev.raw_y = '0;
      end else if (pick < 85) begin
         ev.raw_x = 16'($urandom_range(8192) - 4096);
         ev.raw_y = 16'($urandom_range(8192) - 4096);
      end
      return ev;
   endfunction

   // -------------------------------------------------------------------------
   // Drivers
   // -------------------------------------------------------------------------
   // offer one event, idling first at random, and hold it until its transfer
   task automatic send_event(input event_type ev);
      while ($urandom_range(99) < src_idle_pct) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= ev.opcode;
      req_tdata  <= {5'b0, ev.host_ready, ev.enable_value, ev.raw_y, ev.raw_x,
                     ev.device_code, ev.key_code, ev.pressed};
      @(posedge clock);
      while (!req_tready) begin
         @(posedge clock);
      end
      reports.note_event(ev);
   endtask

   // count only events that the block acts upon
   task automatic run_random(input int unsigned wanted);
      int unsigned counted;
      event_type   ev;
      counted = 0;
      while (counted < wanted) begin
         ev = random_event();
         send_event(ev);
         if (ev.opcode != OP_RESERVED &&
             !(ev.opcode == OP_ANALOG && ev.device_code[6:0] >= SLOTS)) begin
            counted++;
         end
      end
   endtask

   // drop valid and wait for every outstanding report
   task automatic drain_reports();
      req_tvalid <= 1'b0;
      while (reports.pending_reports.size() != 0) begin
         @(posedge clock);
      end
   endtask

   // -------------------------------------------------------------------------
   // Report sink: random stalls, plus long hold-offs on request
   // -------------------------------------------------------------------------
   initial begin : report_sink
      int unsigned hold_left;
      hold_left  = 0;
      rsp_tready = 1'b0;
      forever begin
         @(posedge clock);
         if (sink_hold_request != 0) begin
            hold_left         = sink_hold_request;
            sink_hold_request = 0;
         end
         if (hold_left != 0) begin
            rsp_tready <= 1'b0;
            hold_left--;
         end else begin
            rsp_tready <= ($urandom_range(99) >= sink_idle_pct);
         end
      end
   end

   // check every report transfer
   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) begin
         reports.check_report(rsp_tdata);
      end
   end

   // watchdog
   initial begin : watchdog
      cycle_count = 0;
      while (cycle_count < CYCLE_LIMIT) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("%0t: timeout with %0d reports outstanding", $time,
               reports.pending_reports.size());
      $display("status: fail");
      $finish;
   end

   // -------------------------------------------------------------------------
   // Stimulus
   // -------------------------------------------------------------------------
   initial begin : stimulus
      event_type ev;
      reset             = 1'b1;
      req_tvalid        = 1'b0;
      req_tdata         = '0;
      req_tuser         = OP_KEY;
      src_idle_pct      = 9;
      sink_idle_pct     = 76;
      sink_hold_request = 0;
      repeat (10) @(posedge clock);
      reset <= 1'b0;

      // directed: baseline from reset, then every mapped key with upper bits set
      send_event(key_event(16'd0, 1'b1, 1'b1));
      for (int i = 0; i < 12; i++) begin
         send_event(key_event({9'(i * 37 + 1), mapped_key(i)}, 1'b1, 1'b1));
      end
      // axis extremes saturate both ways
      send_event(analog_event(8'h00, 16'h7FFF, 16'h8000, 1'b1));
      // right slot 1 shows while slot 0 rests, slot 0 wins once it moves
      send_event(analog_event(8'h81, 16'd4095, 16'hF000, 1'b1));
      send_event(analog_event(8'h80, 16'd0, 16'd1, 1'b1));
      send_event(analog_event(8'h80, 16'd0, 16'd0, 1'b1));
      // slots out of range drop; unread slots still report
      send_event(analog_event(8'h85, 16'h1234, 16'h4321, 1'b1));
      send_event(analog_event(8'hFF, 16'hFFFF, 16'hFFFF, 1'b1));
      send_event(analog_event(8'h03, 16'h0100, 16'hFF00, 1'b1));
      // host not ready, disable with a neutral report, silent updates, a report
      send_event(key_event({9'h0, KEY_X}, 1'b0, 1'b0));
      send_event(enable_event(1'b0, 1'b1));
      send_event(key_event({9'h0, KEY_LB}, 1'b0, 1'b1));
      send_event(enable_event(1'b1, 1'b0));
      ev        = '0;
      ev.opcode = OP_RESERVED;
      send_event(ev);
      send_event(key_event({9'h0, KEY_UP}, 1'b0, 1'b1));

      // hold the sink off while events keep coming, so the block fills and stalls
      src_idle_pct      = 0;
      sink_hold_request = SINK_HOLD_CYCLES;
      for (int i = 0; i < 24; i++) begin
         send_event(key_event(16'($urandom), 1'($urandom_range(1)), 1'b1));
      end
      drain_reports();

      // random phases: sender mostly busy, then sink mostly busy, then no idling
      src_idle_pct  = 9;
      sink_idle_pct = 76;
      run_random(RANDOM_PER_PHASE);
      drain_reports();
      src_idle_pct  = 76;
      sink_idle_pct = 9;
      run_random(RANDOM_PER_PHASE);
      src_idle_pct  = 0;
      sink_idle_pct = 0;
      run_random(RANDOM_PER_PHASE);

      drain_reports();
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (reports.mismatches == 0 && reports.pending_reports.size() == 0) begin
         $display("status: pass");
      end else begin
         $display("status: fail");
      end
      $finish;
   end

endmodule

@@ sim.f @@
hw/rtl/gpr_pkg.sv
hw/rtl/gpr_state_keeper.sv
hw/rtl/gpr_report_former.sv
hw/rtl/gamepad_report_builder.sv
sim/testbench.sv
